FILE: rtl/rdq_pkg.sv
package rdq_pkg;

    localparam int COMMAND_W = 3;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;

    // Command codes carried by an input beat.
    typedef enum logic [COMMAND_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_PEEK_FRONT = 3'd4,
        CMD_PEEK_BACK  = 3'd5,
        CMD_REVERSE    = 3'd6,
        CMD_COUNT      = 3'd7
    } command_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic exec;
        logic load_direct;
        logic load_pend;
    } ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic needs_read;
    } dp_stat_t;

endpackage

FILE: rtl/rdq_ctrl.sv
module rdq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  rdq_pkg::dp_stat_t stat,
    output rdq_pkg::ctrl_t   ctrl
);
    import rdq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // The output register can take a new result when it is empty or drains now.
    assign out_free = !out_valid_reg || !out_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!stat.needs_read && out_free)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs of the state machine.
    always_comb
    begin
        ctrl     = '0;
        in_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall    = 1'b0;
                ctrl.accept = in_valid;
            end
            S_EXEC:
            begin
                ctrl.exec        = 1'b1;
                ctrl.load_direct = !stat.needs_read && out_free;
            end
            S_FINISH:
            begin
                ctrl.load_pend = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Output valid flag: set on a load, cleared when the beat is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.load_direct || ctrl.load_pend)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/rdq_datapath.sv
module rdq_datapath #(
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  rdq_pkg::ctrl_t                   ctrl,
    output rdq_pkg::dp_stat_t                stat,
    input  logic [rdq_pkg::COMMAND_W-1:0]    command,
    input  logic signed [rdq_pkg::VALUE_W-1:0] value,
    output logic [rdq_pkg::STATUS_W-1:0]     status,
    output logic signed [rdq_pkg::VALUE_W-1:0] item,
    output logic [$clog2(DEPTH+1)-1:0]       count
);
    import rdq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
    localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);

    // Latched command beat.
    command_t                  cmd_reg;
    logic signed [VALUE_W-1:0] value_reg;

    // Queue state.
    logic [IW-1:0] first_reg;
    logic [IW-1:0] first_next;
    logic [CW-1:0] occ_reg;
    logic [CW-1:0] occ_next;
    logic          rev_reg;
    logic          rev_next;

    // Result waiting for the memory read.
    status_t pend_status_reg;
    logic    pend_read_reg;

    // Output payload.
    status_t                   status_reg;
    logic signed [VALUE_W-1:0] item_reg;
    logic [CW-1:0]             count_reg;

    // Slot memory.
    logic signed [VALUE_W-1:0] mem [DEPTH];
    logic signed [VALUE_W-1:0] rdata_reg;

    logic          is_push;
    logic          is_pop;
    logic          is_peek;
    logic          front_op;
    logic          at_first;
    logic          empty;
    logic          full;
    logic [SW-1:0] tail_sum;
    logic [SW-1:0] last_sum;
    logic [IW-1:0] tail_idx;
    logic [IW-1:0] last_idx;
    logic [IW-1:0] prev_idx;
    logic [IW-1:0] succ_idx;
    logic          we;
    logic          re;
    logic [IW-1:0] waddr;
    logic [IW-1:0] raddr;
    status_t       status_c;

    // Command decode.
    assign is_push  = (cmd_reg == CMD_PUSH_FRONT) || (cmd_reg == CMD_PUSH_BACK);
    assign is_pop   = (cmd_reg == CMD_POP_FRONT) || (cmd_reg == CMD_POP_BACK);
    assign is_peek  = (cmd_reg == CMD_PEEK_FRONT) || (cmd_reg == CMD_PEEK_BACK);
    assign front_op = (cmd_reg == CMD_PUSH_FRONT) || (cmd_reg == CMD_POP_FRONT)
                   || (cmd_reg == CMD_PEEK_FRONT);
    // The reverse flag swaps which physical end a logical end maps to.
    assign at_first = front_op ^ rev_reg;
    assign empty    = (occ_reg == '0);
    assign full     = (occ_reg == DEPTH_C);

    // Ring positions; tail_sum stays below twice the depth, as does last_sum while the queue holds an item.
    assign tail_sum = SW'(first_reg) + SW'(occ_reg);
    assign last_sum = tail_sum - SW'(1);
    assign tail_idx = (tail_sum >= DEPTH_S) ? IW'(tail_sum - DEPTH_S) : IW'(tail_sum);
    assign last_idx = (last_sum >= DEPTH_S) ? IW'(last_sum - DEPTH_S) : IW'(last_sum);
    assign prev_idx = (first_reg == '0) ? LAST_IDX : first_reg - IW'(1);
    assign succ_idx = (first_reg == LAST_IDX) ? '0 : first_reg + IW'(1);

    assign stat.needs_read = (is_pop || is_peek) && !empty;

    assign we    = ctrl.exec && is_push && !full;
    assign re    = ctrl.exec && stat.needs_read;
    assign waddr = at_first ? prev_idx : tail_idx;
    assign raddr = at_first ? first_reg : last_idx;

    // Status of the current command.
    always_comb
    begin
        status_c = ST_OK;
        if (is_push && full)
        begin
            status_c = ST_FULL;
        end
        else if ((is_pop || is_peek) && empty)
        begin
            status_c = ST_EMPTY;
        end
    end

    // Pointer, count and flag updates.
    always_comb
    begin
        first_next = first_reg;
        occ_next   = occ_reg;
        rev_next   = rev_reg;
        if (ctrl.exec)
        begin
            if (we)
            begin
                occ_next = occ_reg + CW'(1);
                if (at_first)
                begin
                    first_next = prev_idx;
                end
            end
            if (is_pop && !empty)
            begin
                occ_next = occ_reg - CW'(1);
                if (at_first)
                begin
                    first_next = succ_idx;
                end
            end
            if (cmd_reg == CMD_REVERSE)
            begin
                rev_next = !rev_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= '0;
            occ_reg   <= '0;
            rev_reg   <= 1'b0;
        end
        else
        begin
            first_reg <= first_next;
            occ_reg   <= occ_next;
            rev_reg   <= rev_next;
        end
    end

    // Slot memory with registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= value_reg;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // Command capture, pending result and output payload.
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            cmd_reg   <= command_t'(command);
            value_reg <= value;
        end
        if (ctrl.exec)
        begin
            pend_status_reg <= status_c;
            pend_read_reg   <= stat.needs_read;
        end
        if (ctrl.load_direct)
        begin
            status_reg <= status_c;
            item_reg   <= '0;
            count_reg  <= occ_next;
        end
        else if (ctrl.load_pend)
        begin
            status_reg <= pend_status_reg;
            item_reg   <= pend_read_reg ? rdata_reg : '0;
            count_reg  <= occ_reg;
        end
    end

    assign status = status_reg;
    assign item   = item_reg;
    assign count  = count_reg;

endmodule

FILE: rtl/reversible_deque.sv
// Channel  Valid      Stall      Payload
// input    in_valid   in_stall   command, value
// output   out_valid  out_stall  status, item, count
//
// A push, reverse, count or failed pop or peek loads its result in the execute
// state after the accept, or in finish under an output stall. A pop or peek of a
// stored value loads it in finish, after the registered slot read. The input is
// freed once the result is loaded; one more item can be accepted while a result
// waits at a stalled output, then holds the controller until the output is free.
// Reset empties the queue and clears the reverse flag; slots are not cleared.
module reversible_deque #(
    parameter int DEPTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [rdq_pkg::COMMAND_W-1:0]      command,
    input  logic signed [rdq_pkg::VALUE_W-1:0] value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [rdq_pkg::STATUS_W-1:0]       status,
    output logic signed [rdq_pkg::VALUE_W-1:0] item,
    output logic [$clog2(DEPTH+1)-1:0]         count
);
    import rdq_pkg::*;

    ctrl_t    ctrl;
    dp_stat_t stat;

    // Sequencing of each command.
    rdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // Ring store, pointers and result registers.
    rdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .stat    (stat),
        .command (command),
        .value   (value),
        .status  (status),
        .item    (item),
        .count   (count)
    );

endmodule

FILE: rtl/rdq_checker.sv
module rdq_checker #(
    parameter int DEPTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [rdq_pkg::STATUS_W-1:0]       status,
    input  logic signed [rdq_pkg::VALUE_W-1:0] item,
    input  logic [$clog2(DEPTH+1)-1:0]         count
);
    import rdq_pkg::*;

    // A stalled result beat stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(item)
            && $stable(count))
    else $error("stalled result beat changed");

    // Only one command is in work at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("second command accepted while one is in work");

    // The count never exceeds the ring depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count <= ($clog2(DEPTH+1))'(DEPTH))
    else $error("count beyond depth");

    // A failed command returns no data.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY || status == ST_FULL) |-> item == '0)
    else $error("failed command returned data");

    // Status carries only defined codes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == ST_OK || status == ST_EMPTY || status == ST_FULL)
    else $error("undefined status code");

endmodule

bind reversible_deque rdq_checker #(
    .DEPTH (DEPTH)
) u_rdq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .item      (item),
    .count     (count)
);

FILE: tb/deque_mirror_pkg.sv
package deque_mirror_pkg;

    import rdq_pkg::*;

    localparam int DEPTH = 16;

    // Shadow copy of the deque that predicts one result per accepted beat
    // and checks the results that the block returns.
    class deque_mirror;

        typedef struct {
            status_t            st;
            logic signed [31:0] item;
            logic [4:0]         count;
        } result_t;

        logic [31:0] slots [DEPTH];
        logic [3:0]  first_idx;
        logic [4:0]  occupancy;
        bit          reversed;
        result_t     pending_results [$];
        int          mismatches;

        function new();
            first_idx  = '0;
            occupancy  = '0;
            reversed   = 1'b0;
            mismatches = 0;
            foreach (slots[i])
                slots[i] = '0;
        endfunction

        // Apply one accepted command to the shadow state and queue its result.
        function void note_command(command_t cmd, logic signed [31:0] v);
            result_t    r;
            bit         at_first;
            logic [3:0] last_idx;
            r.st = ST_OK;
            r.item = '0;
            last_idx = first_idx + 4'(occupancy - 5'd1);
            case (cmd)
                CMD_PUSH_FRONT, CMD_PUSH_BACK:
                begin
                    if (occupancy >= DEPTH)
                    begin
                        r.st = ST_FULL;
                    end
                    else
                    begin
                        at_first = (cmd == CMD_PUSH_FRONT) ^ reversed;
                        if (at_first)
                        begin
                            first_idx = first_idx - 4'd1;
                            slots[first_idx] = v;
                        end
                        else
                        begin
                            slots[4'(first_idx + occupancy[3:0])] = v;
                        end
                        occupancy = occupancy + 5'd1;
                    end
                end
                CMD_POP_FRONT, CMD_POP_BACK:
                begin
                    if (occupancy == 0)
                    begin
                        r.st = ST_EMPTY;
                    end
                    else
                    begin
                        at_first = (cmd == CMD_POP_FRONT) ^ reversed;
                        if (at_first)
                        begin
                            r.item = slots[first_idx];
                            first_idx = first_idx + 4'd1;
                        end
                        else
                        begin
                            r.item = slots[last_idx];
                        end
                        occupancy = occupancy - 5'd1;
                    end
                end
                CMD_PEEK_FRONT, CMD_PEEK_BACK:
                begin
                    if (occupancy == 0)
                    begin
                        r.st = ST_EMPTY;
                    end
                    else
                    begin
                        at_first = (cmd == CMD_PEEK_FRONT) ^ reversed;
                        r.item = at_first ? slots[first_idx] : slots[last_idx];
                    end
                end
                CMD_REVERSE:
                begin
                    reversed = !reversed;
                end
                default:
                begin
                end
            endcase
            r.count = occupancy;
            pending_results.insert(pending_results.size(), r);
        endfunction

        // Compare one returned beat with the oldest prediction.
        function void check_result(logic [1:0] st, logic signed [31:0] it,
                                   logic [4:0] cnt);
            result_t e;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: st %0d item %0d count %0d",
                             st, it, cnt);
                return;
            end
            e = pending_results[0];
            pending_results.delete(0);
            if (st !== e.st || it !== e.item || cnt !== e.count)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp st %0d item %0d count %0d, got %0d %0d %0d",
                             e.st, e.item, e.count, st, it, cnt);
            end
        endfunction

    endclass

endpackage

FILE: tb/reversible_deque_test.sv
module reversible_deque_test;

    import rdq_pkg::*;
    import deque_mirror_pkg::*;

    localparam int HOLD_CYCLES  = 80;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BEATS = 480;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         command;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         status;
    logic signed [31:0] item;
    logic [4:0]         count;

    deque_mirror mirror;
    bit          quiet;
    bit          sender_calm;
    bit          hold_request;
    int          cycles;

    reversible_deque #(.DEPTH(DEPTH)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .item      (item),
        .count     (count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Result monitor: every accepted output beat is checked.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            mirror.check_result(status, item, count);
    end

    // Receiver: random stall bursts, one long hold-off on request.
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(20, 40)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // Offer one command beat and wait until the block takes it.
    task automatic send_command(input command_t cmd, input logic [31:0] v);
        int gap;
        if (!quiet && !sender_calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        value    <= v;
        do
            @(posedge clk);
        while (in_stall);
        mirror.note_command(cmd, v);
    endtask

    // Push values lean toward the extremes now and then.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Bias 0 fills the deque, bias 1 drains it, anything else is uniform.
    function automatic command_t pick_command(int bias);
        int r;
        r = $urandom_range(0, 99);
        if (bias == 0 && r < 70)
            return command_t'($urandom_range(0, 1));
        if (bias == 1 && r < 70)
            return command_t'($urandom_range(2, 3));
        return command_t'($urandom_range(0, 7));
    endfunction

    initial
    begin
        int sent;
        int phase_len;
        int bias;
        bit held;
        mirror       = new();
        quiet        = 1'b0;
        sender_calm  = 1'b0;
        hold_request = 1'b0;
        held         = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        command      = CMD_COUNT;
        value        = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty queue, extremes of value, every command, reversal.
        send_command(CMD_POP_FRONT, 32'h0);
        send_command(CMD_POP_BACK, 32'h0);
        send_command(CMD_PEEK_FRONT, 32'h0);
        send_command(CMD_PEEK_BACK, 32'h0);
        send_command(CMD_COUNT, 32'hffff_ffff);
        send_command(CMD_PUSH_FRONT, 32'h8000_0000);
        send_command(CMD_PUSH_BACK, 32'h7fff_ffff);
        send_command(CMD_PUSH_FRONT, 32'h0000_0000);
        send_command(CMD_PUSH_BACK, 32'hffff_ffff);
        send_command(CMD_PEEK_FRONT, 32'h0);
        send_command(CMD_PEEK_BACK, 32'h0);
        send_command(CMD_REVERSE, 32'h5555_aaaa);
        send_command(CMD_PEEK_FRONT, 32'h0);
        send_command(CMD_PEEK_BACK, 32'h0);
        send_command(CMD_PUSH_FRONT, 32'h1234_5678);
        send_command(CMD_PUSH_BACK, 32'hedcb_a987);
        send_command(CMD_POP_FRONT, 32'h0);
        send_command(CMD_POP_BACK, 32'h0);
        send_command(CMD_COUNT, 32'h0);
        send_command(CMD_REVERSE, 32'h0);
        send_command(CMD_POP_FRONT, 32'h0);
        send_command(CMD_POP_BACK, 32'h0);
        send_command(CMD_POP_FRONT, 32'h0);
        send_command(CMD_POP_BACK, 32'h0);
        send_command(CMD_COUNT, 32'h0);

        // Random phases that fill, drain or mix; fills run into the full case.
        sent = 0;
        while (sent < RANDOM_BEATS)
        begin
            phase_len   = $urandom_range(15, 40);
            bias        = $urandom_range(0, 2);
            sender_calm = ($urandom_range(0, 3) == 0);
            quiet       = (sent >= RANDOM_BEATS - 80);
            if (!held && sent >= 180)
            begin
                // Long receiver hold-off while pushes keep coming.
                held         = 1'b1;
                hold_request = 1'b1;
                bias         = 0;
            end
            repeat (phase_len)
            begin
                send_command(pick_command(bias), pick_value());
                sent++;
            end
        end
        in_valid <= 1'b0;

        // Drain every expected result, then wait so that any unexpected beat is still seen.
        while (mirror.pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mirror.mismatches == 0 && mirror.pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
